// File: hw/rtl/sdpp_pkg.sv
// ----------------------------------------------------------------------------
// sdpp_pkg: shared types and constants of the step/direction positioner
// Request/response payloads, codes, and controller/datapath interface.
// ----------------------------------------------------------------------------
package sdpp_pkg;

    // Default widths of the position and period counters
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int PERIOD_WIDTH_DEF   = 16;

    // Timebase and accepted rate window
    localparam int          DIV_W            = 20;
    localparam int          DIV_CNT_W        = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] TICKS_PER_SECOND = 20'd1000000;
    localparam logic [19:0] RATE_MIN         = 20'd20;
    localparam logic [19:0] RATE_MAX         = 20'd100000;

    // Request types
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_RELATIVE = 2'd1;
    localparam logic [1:0] REQ_ABSOLUTE = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Response status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
    localparam logic [1:0] STATUS_BUSY      = 2'd2;
    localparam logic [1:0] STATUS_BAD_RATE  = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] move_value;
        logic [19:0]        step_rate_hz;
        logic               move_direction;
    } req_t;

    typedef struct packed {
        logic               step_level;
        logic               direction_level;
        logic               busy_res;
        logic signed [31:0] position;
        logic               move_done;
        logic [1:0]         status;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // apply the request at the port
        logic load_out;   // load the response from the request just applied
        logic start_div;  // launch the period division
        logic load_div;   // load the period and the response of a started move
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_div;  // request at the port starts a move
        logic div_done;   // quotient ready
    } dp_stat_t;

endpackage

// File: hw/rtl/sdpp_div.sv
// ----------------------------------------------------------------------------
// sdpp_div: restoring divider for the step period
// Divides the timebase rate by the requested step rate, one bit per cycle.
// ----------------------------------------------------------------------------
module sdpp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sdpp_pkg::DIV_W-1:0]    divisor,
    output logic [sdpp_pkg::DIV_W-1:0]    quotient,
    output logic                          done
);

    logic [sdpp_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [sdpp_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [sdpp_pkg::DIV_W-1:0]     dvs_reg, dvs_next;
    logic [sdpp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [sdpp_pkg::DIV_W:0]       shifted;
    logic [sdpp_pkg::DIV_W:0]       diff;

    assign shifted = {rem_reg, quo_reg[sdpp_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = sdpp_pkg::TICKS_PER_SECOND;
            dvs_next  = divisor;
            cnt_next  = sdpp_pkg::DIV_CNT_W'(sdpp_pkg::DIV_W);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            // Subtract when the shifted remainder covers the divisor
            if (!diff[sdpp_pkg::DIV_W])
            begin
                rem_next = diff[sdpp_pkg::DIV_W-1:0];
                quo_next = {quo_reg[sdpp_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[sdpp_pkg::DIV_W-1:0];
                quo_next = {quo_reg[sdpp_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sdpp_pkg::DIV_CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: hw/rtl/sdpp_datapath.sv
// ----------------------------------------------------------------------------
// sdpp_datapath: position, pulse and phase state with the response register
// Applies ticks and move commands, and holds the period divider.
// ----------------------------------------------------------------------------
module sdpp_datapath #(
    parameter int POSITION_WIDTH = sdpp_pkg::POSITION_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = sdpp_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdpp_pkg::req_t        req_data,
    input  sdpp_pkg::ctrl_cmd_t   cmd,
    output sdpp_pkg::dp_stat_t    stat,
    output sdpp_pkg::rsp_t        rsp_data
);

    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [PERIOD_WIDTH-1:0]   PER_ONE = PERIOD_WIDTH'(1);

    logic signed [POSITION_WIDTH-1:0] cur_pos_reg, cur_pos_next;
    logic [31:0]                      pulses_reg, pulses_next;
    logic [PERIOD_WIDTH-1:0]          reload_reg, reload_next;
    logic [PERIOD_WIDTH-1:0]          phase_reg, phase_next;
    logic                             dir_reg, dir_next;
    logic                             running_reg, running_next;
    sdpp_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                             rate_ok;
    logic signed [POSITION_WIDTH-1:0] sval;
    logic [POSITION_WIDTH-1:0]        span;
    logic [POSITION_WIDTH+31:0]       dist_ext;
    logic [31:0]                      abs_pulses;
    logic                             step_tick;
    logic                             step_after;
    logic                             done;
    logic [1:0]                       status;
    logic                             needs_div;
    logic [sdpp_pkg::DIV_W-1:0]       quotient;
    logic                             div_done;
    logic [PERIOD_WIDTH-1:0]          div_reload;

    sdpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .divisor  (req_data.step_rate_hz),
        .quotient (quotient),
        .done     (div_done)
    );

    assign rate_ok = (req_data.step_rate_hz >= sdpp_pkg::RATE_MIN) &&
                     (req_data.step_rate_hz <= sdpp_pkg::RATE_MAX);
    assign sval    = POSITION_WIDTH'($signed(req_data.move_value));

    // Distance to an absolute target, clamped to the 32-bit pulse counter
    assign span       = (sval > cur_pos_reg) ? (sval - cur_pos_reg) : (cur_pos_reg - sval);
    assign dist_ext   = {32'd0, span};
    assign abs_pulses = (|dist_ext[POSITION_WIDTH+31:32]) ? 32'hFFFF_FFFF : dist_ext[31:0];

    assign step_tick  = running_reg && (phase_reg >= (reload_reg >> 1));
    assign div_reload = PERIOD_WIDTH'(quotient - 1'b1);

    always_comb
    begin
        cur_pos_next = cur_pos_reg;
        pulses_next  = pulses_reg;
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        running_next = running_reg;
        done         = 1'b0;
        status       = sdpp_pkg::STATUS_OK;
        needs_div    = 1'b0;
        unique case (req_data.req_type)
            sdpp_pkg::REQ_TICK:
            begin
                if (running_reg)
                begin
                    if (phase_reg == reload_reg)
                    begin
                        phase_next   = '0;
                        cur_pos_next = dir_reg ? cur_pos_reg + POS_ONE
                                               : cur_pos_reg - POS_ONE;
                        pulses_next  = pulses_reg - 1'b1;
                        if (pulses_reg == 32'd1)
                        begin
                            running_next = 1'b0;
                            done         = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + PER_ONE;
                    end
                end
            end
            sdpp_pkg::REQ_RELATIVE:
            begin
                priority if (req_data.move_value[31] || (req_data.move_value == '0))
                begin
                    status = sdpp_pkg::STATUS_BAD_COUNT;
                end
                else if (running_reg)
                begin
                    status = sdpp_pkg::STATUS_BUSY;
                end
                else if (!rate_ok)
                begin
                    status = sdpp_pkg::STATUS_BAD_RATE;
                end
                else
                begin
                    dir_next     = req_data.move_direction;
                    pulses_next  = req_data.move_value;
                    phase_next   = '0;
                    running_next = 1'b1;
                    needs_div    = 1'b1;
                end
            end
            sdpp_pkg::REQ_ABSOLUTE:
            begin
                // Abort first; the position is already exact
                running_next = 1'b0;
                phase_next   = '0;
                pulses_next  = '0;
                if (!rate_ok)
                begin
                    status = sdpp_pkg::STATUS_BAD_RATE;
                end
                else if (sval != cur_pos_reg)
                begin
                    dir_next     = (sval > cur_pos_reg);
                    pulses_next  = abs_pulses;
                    running_next = 1'b1;
                    needs_div    = 1'b1;
                end
            end
            sdpp_pkg::REQ_RESERVED:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign step_after = running_next && (phase_next >= (reload_reg >> 1));

    always_comb
    begin
        rsp_next   = rsp_reg;
        reload_next = reload_reg;
        if (cmd.load_out)
        begin
            rsp_next.step_level      = (req_data.req_type == sdpp_pkg::REQ_TICK) ? step_tick
                                                                               : step_after;
            rsp_next.direction_level = dir_next;
            rsp_next.busy_res        = running_next;
            rsp_next.position        = 32'(cur_pos_next);
            rsp_next.move_done       = done;
            rsp_next.status          = status;
        end
        else if (cmd.load_div)
        begin
            // New move: phase is zero, so the pin is high only for a tiny period
            reload_next              = div_reload;
            rsp_next.step_level      = ((div_reload >> 1) == '0);
            rsp_next.direction_level = dir_reg;
            rsp_next.busy_res        = running_reg;
            rsp_next.position        = 32'(cur_pos_reg);
            rsp_next.move_done       = 1'b0;
            rsp_next.status          = sdpp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= '0;
            pulses_reg  <= '0;
            reload_reg  <= '0;
            phase_reg   <= '0;
            dir_reg     <= 1'b1;
            running_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cur_pos_reg <= cur_pos_next;
                pulses_reg  <= pulses_next;
                phase_reg   <= phase_next;
                dir_reg     <= dir_next;
                running_reg <= running_next;
            end
            reload_reg <= reload_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign stat.needs_div = needs_div;
    assign stat.div_done  = div_done;
    assign rsp_data       = rsp_reg;

    // An idle positioner has no pulses pending
    a_idle_no_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (pulses_reg == '0))
        else $error("pulses pending while idle");

    // The phase never passes the reload point of a running move
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (phase_reg <= reload_reg))
        else $error("phase beyond period");

    // Position changes only on an accepted request
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> $stable(cur_pos_reg))
        else $error("position changed without a request");

endmodule

// File: hw/rtl/sdpp_ctrl.sv
// ----------------------------------------------------------------------------
// sdpp_ctrl: request/response sequencer
// Takes requests, waits out the period division, and owns response valid.
// ----------------------------------------------------------------------------
module sdpp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  sdpp_pkg::dp_stat_t   stat,
    output sdpp_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic state_reg, state_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic out_free;

    // Response register is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        req_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = !out_free;
                if (req_valid && out_free)
                begin
                    cmd.accept = 1'b1;
                    if (stat.needs_div)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.load_out   = 1'b1;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done && out_free)
                begin
                    cmd.load_div   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: hw/rtl/step_dir_pulse_positioner_top.sv
// ----------------------------------------------------------------------------
// step_dir_pulse_positioner_top: step/direction pulse positioner
// Runs relative and absolute moves on a 1 us tick and tracks signed position.
// ----------------------------------------------------------------------------
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+-----------------------------
//  request  | req_valid  in,  req_stall out   | sdpp_pkg::req_t  (req_data)
//  response | rsp_valid  out, rsp_stall in    | sdpp_pkg::rsp_t  (rsp_data)
//
//  A tick, a rejected command, or an absolute move that only stops is answered
//  without the divider. A command that starts a move passes the accept, the 20
//  steps of the bit-serial period divider, and the load of the response.
//  Reset is asynchronous, active low; position 0, direction clockwise, idle.
//  Hold req_stall high through the division and while a response waits under
//  rsp_stall; a response drained on an edge lets the next request in on it.
//
// Every request yields exactly one response. While a move runs, each tick
// advances the phase counter; the step pin is low for the first half of the
// period and high for the rest. When a pulse ends the position moves one
// step in the direction pin's sense, and the last pulse raises move_done.
// The period reload is 1000000/rate - 1, computed by the shared divider.
// ----------------------------------------------------------------------------
module step_dir_pulse_positioner_top #(
    parameter int POSITION_WIDTH = sdpp_pkg::POSITION_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = sdpp_pkg::PERIOD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sdpp_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sdpp_pkg::rsp_t  rsp_data
);

    sdpp_pkg::ctrl_cmd_t cmd;
    sdpp_pkg::dp_stat_t  stat;

    // Sequencer: handshakes and the wait for the divider
    sdpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: motion state, divider and the response register
    sdpp_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .PERIOD_WIDTH   (PERIOD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_data (rsp_data)
    );

    // The last pulse ends the move
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.move_done && rsp_data.busy_res))
        else $error("move_done while still busy");

    // A rejected command never finishes a move
    a_reject_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status != sdpp_pkg::STATUS_OK)) |-> !rsp_data.move_done)
        else $error("move_done on a rejected command");

    // No request is taken while the divider works
    a_stall_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> req_stall)
        else $error("request taken during division");

endmodule

// File: test/tb_step_dir_pulse_positioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_step_dir_pulse_positioner_top: self-checking bench of the step positioner
// Walks a short table of ticks and move commands, then a long random mix, and
// checks every response field against a cycle-free model of the pin state.
// ----------------------------------------------------------------------------
module tb_step_dir_pulse_positioner_top;

    localparam int PLAN_ROWS    = 15;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_AT      = 140;     // accepted transfers before the long hold
    localparam int HOLD_CYCLES  = 400;     // length of the long response hold-off
    localparam int PAUSE_AT     = 300;     // random item at which the sender drains
    localparam int DRAIN_CYCLES = 40;      // idle margin after the last response
    localparam int CYCLE_LIMIT  = 200000;

    // One row of the directed table. Rows marked typed carry their expected
    // status; all of them sit before any move, so the rest of the response is
    // the reset state (idle, clockwise, position 0).
    typedef struct packed {
        sdpp_pkg::req_t req;
        int             reps;
        logic           typed;
        logic [1:0]     want_status;
    } plan_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    sdpp_pkg::req_t req_data  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    sdpp_pkg::rsp_t rsp_data;

    // Expectation that travels with the request being offered; driven with
    // nonblocking assignments so it lines up with req_data at the accept edge.
    logic           want_typed = 1'b0;
    sdpp_pkg::rsp_t want_fixed = '0;

    sdpp_pkg::rsp_t pending_pin_states [$];
    plan_row_t      plan [PLAN_ROWS];
    int             send_idle_pct  = 29;
    int             recv_idle_pct  = 51;
    int             mismatch_count = 0;
    int             accepted_count = 0;
    int             rsp_count      = 0;
    int             cycle_count    = 0;

    // Model state of the positioner
    logic signed [31:0] pos_now     = '0;
    logic signed [31:0] tgt_pos     = '0;
    logic        [31:0] pulses_todo = '0;
    logic        [15:0] reload_ctr  = '0;
    logic        [15:0] phase_ctr   = '0;
    logic               dir_cw      = 1'b1;
    logic               motion_on   = 1'b0;

    step_dir_pulse_positioner_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the model by one request and return the pin state it shows.
    function automatic sdpp_pkg::rsp_t next_pin_state(input sdpp_pkg::req_t r);
        sdpp_pkg::rsp_t o;
        logic           rate_ok;
        logic [19:0]    quot;
        logic [31:0]    span;
        o       = '0;
        rate_ok = (r.step_rate_hz >= sdpp_pkg::RATE_MIN) &&
                  (r.step_rate_hz <= sdpp_pkg::RATE_MAX);
        quot    = '0;
        span    = '0;
        case (r.req_type)
            sdpp_pkg::REQ_TICK:
            begin
                if (motion_on)
                begin
                    // take the level from the phase before it advances
                    o.step_level = (phase_ctr >= (reload_ctr >> 1));
                    if (phase_ctr == reload_ctr)
                    begin
                        phase_ctr   = '0;
                        pos_now     = dir_cw ? pos_now + 32'sd1 : pos_now - 32'sd1;
                        pulses_todo = pulses_todo - 32'd1;
                        if (pulses_todo == 32'd0)
                        begin
                            motion_on   = 1'b0;
                            o.move_done = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_ctr = phase_ctr + 16'd1;
                    end
                end
            end
            sdpp_pkg::REQ_RELATIVE:
            begin
                if (r.move_value <= 0)
                    o.status = sdpp_pkg::STATUS_BAD_COUNT;
                else if (motion_on)
                    o.status = sdpp_pkg::STATUS_BUSY;
                else if (!rate_ok)
                    o.status = sdpp_pkg::STATUS_BAD_RATE;
                else
                begin
                    dir_cw      = r.move_direction;
                    tgt_pos     = dir_cw ? pos_now + r.move_value : pos_now - r.move_value;
                    pulses_todo = 32'(r.move_value);
                    quot        = sdpp_pkg::TICKS_PER_SECOND / r.step_rate_hz;
                    reload_ctr  = 16'(quot - 20'd1);
                    phase_ctr   = '0;
                    motion_on   = 1'b1;
                end
            end
            sdpp_pkg::REQ_ABSOLUTE:
            begin
                // abort whatever runs, even when the rate turns out bad
                motion_on   = 1'b0;
                phase_ctr   = '0;
                pulses_todo = '0;
                if (!rate_ok)
                    o.status = sdpp_pkg::STATUS_BAD_RATE;
                else
                begin
                    tgt_pos = r.move_value;
                    if (tgt_pos != pos_now)
                    begin
                        if (tgt_pos > pos_now)
                        begin
                            dir_cw = 1'b1;
                            span   = 32'(tgt_pos - pos_now);
                        end
                        else
                        begin
                            dir_cw = 1'b0;
                            span   = 32'(pos_now - tgt_pos);
                        end
                        pulses_todo = span;
                        quot        = sdpp_pkg::TICKS_PER_SECOND / r.step_rate_hz;
                        reload_ctr  = 16'(quot - 20'd1);
                        motion_on   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        // commands and reserved requests report the level without advancing
        if (r.req_type != sdpp_pkg::REQ_TICK)
            o.step_level = motion_on && (phase_ctr >= (reload_ctr >> 1));
        o.direction_level = dir_cw;
        o.busy_res        = motion_on;
        o.position        = pos_now;
        return o;
    endfunction

    function automatic plan_row_t mk_row(input logic [1:0] kind, input logic [31:0] val,
                                         input logic [19:0] rate, input logic dirn,
                                         input int reps, input logic typed,
                                         input logic [1:0] st);
        plan_row_t p;
        p.req.req_type       = kind;
        p.req.move_value     = val;
        p.req.step_rate_hz   = rate;
        p.req.move_direction = dirn;
        p.reps               = reps;
        p.typed              = typed;
        p.want_status        = st;
        return p;
    endfunction

    // Random request: mostly ticks, short well-formed moves at fast rates so
    // that pulses finish, a few far or slow moves, and some malformed noise.
    function automatic sdpp_pkg::req_t pick_request();
        sdpp_pkg::req_t r;
        int unsigned    roll;
        int unsigned    sub;
        roll             = $urandom_range(0, 999);
        sub              = $urandom_range(0, 3);
        r.req_type       = sdpp_pkg::REQ_TICK;
        r.move_value     = $urandom;
        r.step_rate_hz   = 20'($urandom);
        r.move_direction = 1'($urandom);
        if (roll < 870)
        begin
            r.req_type = sdpp_pkg::REQ_TICK;
        end
        else if (roll < 930)
        begin
            r.req_type     = sdpp_pkg::REQ_RELATIVE;
            r.move_value   = $urandom_range(1, 3);
            r.step_rate_hz = (sub == 0)
                             ? 20'($urandom_range(sdpp_pkg::RATE_MIN, sdpp_pkg::RATE_MAX))
                             : 20'($urandom_range(50000, sdpp_pkg::RATE_MAX));
        end
        else if (roll < 960)
        begin
            r.req_type     = sdpp_pkg::REQ_ABSOLUTE;
            r.move_value   = (sub == 0) ? $urandom : $urandom_range(0, 8) - 4;
            r.step_rate_hz = (sub == 1)
                             ? 20'($urandom_range(sdpp_pkg::RATE_MIN, sdpp_pkg::RATE_MAX))
                             : 20'($urandom_range(50000, sdpp_pkg::RATE_MAX));
        end
        else
        begin
            case (sub)
                0:
                begin
                    r.req_type   = sdpp_pkg::REQ_RELATIVE;
                    r.move_value = ($urandom_range(0, 1) == 0) ? 32'd0
                                                                : ($urandom | 32'h8000_0000);
                end
                1:
                begin
                    r.req_type     = ($urandom_range(0, 1) == 0) ? sdpp_pkg::REQ_RELATIVE
                                                                 : sdpp_pkg::REQ_ABSOLUTE;
                    r.move_value   = $urandom_range(1, 4);
                    r.step_rate_hz = ($urandom_range(0, 1) == 0)
                                     ? 20'($urandom_range(0, sdpp_pkg::RATE_MIN - 1))
                                     : 20'($urandom_range(sdpp_pkg::RATE_MAX + 1, 20'hFFFFF));
                end
                2:       r.req_type = sdpp_pkg::REQ_RESERVED;
                default: r.req_type = sdpp_pkg::REQ_RELATIVE;
            endcase
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want_v);
        $display("MISMATCH response %0d %s: got %0h expected %0h", rsp_count, what, got, want_v);
        mismatch_count++;
    endtask

    // Offer one request and hold it until the transfer happens.
    task automatic offer_request(input sdpp_pkg::req_t r, input logic typed,
                                 input sdpp_pkg::rsp_t fixed);
        req_valid  <= 1'b1;
        req_data   <= r;
        want_typed <= typed;
        want_fixed <= fixed;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic maybe_idle_sender();
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Watch both channels at the edge. Check the response first so that a
    // request accepted on the same edge can never be mistaken for its match.
    always @(posedge clk)
    begin : watch_channels
        sdpp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_pin_states.size() == 0)
            begin
                log_mismatch("unexpected response, position", rsp_data.position, '0);
            end
            else
            begin
                want = pending_pin_states.pop_front();
                if (rsp_data.step_level !== want.step_level)
                    log_mismatch("step_level", 32'(rsp_data.step_level), 32'(want.step_level));
                if (rsp_data.direction_level !== want.direction_level)
                    log_mismatch("direction_level", 32'(rsp_data.direction_level),
                                 32'(want.direction_level));
                if (rsp_data.busy_res !== want.busy_res)
                    log_mismatch("busy_res", 32'(rsp_data.busy_res), 32'(want.busy_res));
                if (rsp_data.position !== want.position)
                    log_mismatch("position", rsp_data.position, want.position);
                if (rsp_data.move_done !== want.move_done)
                    log_mismatch("move_done", 32'(rsp_data.move_done), 32'(want.move_done));
                if (rsp_data.status !== want.status)
                    log_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
            rsp_count++;
        end
        if (rst_n && req_valid && !req_stall)
        begin
            // advance the model on every transfer; typed rows override the value
            want = next_pin_state(req_data);
            pending_pin_states.push_back(want_typed ? want_fixed : want);
            accepted_count++;
        end
    end

    // Response side: random stall at the current rate, plus one long hold-off
    // while the sender keeps offering, so the block backs up into req_stall.
    initial
    begin : rsp_side
        int   held;
        logic hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && accepted_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    rsp_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int             row;
        int             k;
        int             n;
        sdpp_pkg::rsp_t fixed;
        // Directed table: rejects and extremes from reset, then a short move
        // run to its end, a busy reject, a far slow absolute move aborted by
        // a bad-rate absolute, and a maximum count relative move left running.
        plan[0]  = mk_row(sdpp_pkg::REQ_TICK,     32'd0,          20'd0,      1'b0, 1, 1'b1,
                          sdpp_pkg::STATUS_OK);
        plan[1]  = mk_row(sdpp_pkg::REQ_RESERVED, 32'hFFFF_FFFF,  20'hFFFFF,  1'b1, 1, 1'b1,
                          sdpp_pkg::STATUS_OK);
        plan[2]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'd0,          20'd1000,   1'b1, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_COUNT);
        plan[3]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'h8000_0000,  20'd1000,   1'b0, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_COUNT);
        plan[4]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'h7FFF_FFFF,
                          sdpp_pkg::RATE_MIN - 20'd1, 1'b0, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_RATE);
        plan[5]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'd5,
                          sdpp_pkg::RATE_MAX + 20'd1, 1'b1, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_RATE);
        plan[6]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'd5,          20'hFFFFF,  1'b0, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_RATE);
        plan[7]  = mk_row(sdpp_pkg::REQ_ABSOLUTE, 32'd10,         20'd0,      1'b1, 1, 1'b1,
                          sdpp_pkg::STATUS_BAD_RATE);
        plan[8]  = mk_row(sdpp_pkg::REQ_ABSOLUTE, 32'd0,  sdpp_pkg::RATE_MAX, 1'b0, 1, 1'b1,
                          sdpp_pkg::STATUS_OK);
        plan[9]  = mk_row(sdpp_pkg::REQ_RELATIVE, 32'd1,  sdpp_pkg::RATE_MAX, 1'b1, 1, 1'b0,
                          sdpp_pkg::STATUS_OK);
        plan[10] = mk_row(sdpp_pkg::REQ_RELATIVE, 32'd2,  sdpp_pkg::RATE_MAX, 1'b1, 1, 1'b0,
                          sdpp_pkg::STATUS_OK);
        plan[11] = mk_row(sdpp_pkg::REQ_TICK,     32'd0,          20'd0,      1'b0, 10, 1'b0,
                          sdpp_pkg::STATUS_OK);
        plan[12] = mk_row(sdpp_pkg::REQ_ABSOLUTE, 32'h8000_0000,
                          sdpp_pkg::RATE_MIN, 1'b1, 2, 1'b0, sdpp_pkg::STATUS_OK);
        plan[13] = mk_row(sdpp_pkg::REQ_ABSOLUTE, 32'd3,
                          sdpp_pkg::RATE_MAX + 20'd1, 1'b1, 1, 1'b0,
                          sdpp_pkg::STATUS_OK);
        plan[14] = mk_row(sdpp_pkg::REQ_RELATIVE, 32'h7FFF_FFFF,
                          sdpp_pkg::RATE_MAX, 1'b0, 1, 1'b0, sdpp_pkg::STATUS_OK);

        // Hold reset, then release it on an edge.
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
        begin
            for (k = 0; k < plan[row].reps; k++)
            begin
                fixed        = '0;
                fixed.direction_level = 1'b1;
                fixed.status = plan[row].want_status;
                offer_request(plan[row].req, plan[row].typed, fixed);
                maybe_idle_sender();
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // swap the idle rates, then run without idling
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 29;
            end
            if (n == (2 * RANDOM_ITEMS) / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // drop valid and wait until every response is back
            if (n == PAUSE_AT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (pending_pin_states.size() != 0)
                    @(posedge clk);
            end
            offer_request(pick_request(), 1'b0, '0);
            maybe_idle_sender();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_pin_states.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sdpp_pkg.sv
hw/rtl/sdpp_div.sv
hw/rtl/sdpp_datapath.sv
hw/rtl/sdpp_ctrl.sv
hw/rtl/step_dir_pulse_positioner_top.sv
test/tb_step_dir_pulse_positioner_top.sv
